// ===== rtl/bmm_pkg.sv =====
`timescale 1ns / 1ps

package bmm_pkg;

  localparam int WORD_BITS   = 64;
  localparam int MAX_ERRORS  = 7;
  localparam int LEVELS      = MAX_ERRORS + 1;
  localparam int STORE_DEPTH = 64;

  localparam int SYM_W      = 8;
  localparam int IDX_W      = 6;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 7;
  localparam int ERR_W      = 3;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // holds 0..WORD_BITS
  localparam int SHIFT_W = $clog2(WORD_BITS) + 1;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef logic [WORD_BITS-1:0]              word_t;
  typedef logic [STORE_DEPTH-1:0][SYM_W-1:0] pat_store_t;
  typedef logic [LEVELS-1:0][WORD_BITS-1:0]  level_masks_t;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUBJ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PAD   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXERR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED  = 2'd2;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

endpackage

// ===== rtl/bmm_in_if.sv =====
`timescale 1ns / 1ps

interface bmm_in_if;
  logic                      valid;
  logic                      ready;
  logic [bmm_pkg::MODE_W-1:0] mode;
  logic [bmm_pkg::SYM_W-1:0]  symbol;
  logic [bmm_pkg::IDX_W-1:0]  pattern_index;

  modport source (output valid, output mode, output symbol, output pattern_index,
                  input ready);
  modport sink   (input valid, input mode, input symbol, input pattern_index,
                  output ready);
endinterface

// ===== rtl/bmm_out_if.sv =====
`timescale 1ns / 1ps

interface bmm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bmm_pkg::POS_W-1:0] match_start;
  logic [bmm_pkg::ERR_W-1:0]        mismatch_count;

  modport source (output valid, output match_start, output mismatch_count,
                  input ready);
  modport sink   (input valid, input match_start, input mismatch_count,
                  output ready);
endinterface

// ===== rtl/bmm_mask_gen.sv =====
`timescale 1ns / 1ps

// Per-symbol mismatch mask: bit j flags pattern entry (length-1-j).
module bmm_mask_gen (
  input  bmm_pkg::pat_store_t           pattern_i,
  input  logic [bmm_pkg::SYM_W-1:0]     symbol_i,
  input  logic                          fixed_mode_i,
  input  logic [bmm_pkg::SHIFT_W-1:0]   length_i,
  output bmm_pkg::word_t                mask_o
);

  bmm_pkg::word_t                rev_miss;
  logic [bmm_pkg::SHIFT_W-1:0]   shamt;

  always_comb begin
    for (int i = 0; i < bmm_pkg::WORD_BITS; i++) begin
      if (fixed_mode_i) begin
        rev_miss[bmm_pkg::WORD_BITS-1-i] = (pattern_i[i] != symbol_i);
      end else begin
        rev_miss[bmm_pkg::WORD_BITS-1-i] = ~|(pattern_i[i] & symbol_i);
      end
    end
  end

  // entry i lands on bit (length-1-i); entries past the length fall off
  assign shamt  = bmm_pkg::SHIFT_W'(bmm_pkg::WORD_BITS) - length_i;
  assign mask_o = rev_miss >> shamt;

endmodule

// ===== rtl/bitap_mismatch_matcher_unit.sv =====
`timescale 1ns / 1ps

// Path: an item is captured in the input register at its input transfer, then
// its result goes to the result register; load and start items give no result.
// Throughput: one item per cycle unless a pending result waits on out_o.ready;
// the error mask update loop is combinational.
// Reset: length 1, mismatch limit 0, fixed mode; masks and position as after a
// start with length 1. The pattern store is not cleared and must be loaded first.
module bitap_mismatch_matcher_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bmm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  bmm_in_if.sink                            in_i,
  bmm_out_if.source                         out_o
);

  // configuration
  logic [bmm_pkg::LEN_W-1:0]  len_q;
  logic [bmm_pkg::ERR_W-1:0]  maxerr_q;
  logic                       fixed_q;

  // input stage
  logic                       s1_valid_q;
  logic [bmm_pkg::MODE_W-1:0] s1_mode_q;
  logic [bmm_pkg::SYM_W-1:0]  s1_sym_q;
  logic [bmm_pkg::IDX_W-1:0]  s1_idx_q;

  // matcher state
  bmm_pkg::pat_store_t                store_q;
  bmm_pkg::level_masks_t              masks_q;
  bmm_pkg::level_masks_t              masks_d;
  bmm_pkg::level_masks_t              init_masks;
  logic signed [bmm_pkg::POS_W-1:0]   pos_q;

  // result register
  logic                               out_valid_q;
  logic signed [bmm_pkg::POS_W-1:0]   out_start_q;
  logic [bmm_pkg::ERR_W-1:0]          out_count_q;

  logic                        fire;
  logic                        accept;
  logic                        is_scan;
  logic [bmm_pkg::SHIFT_W-1:0] eff_len;
  logic [bmm_pkg::LVL_W-1:0]   eff_k;
  bmm_pkg::word_t              sym_mask;
  bmm_pkg::word_t              pm;
  bmm_pkg::word_t              prev_shift;
  bmm_pkg::word_t              cur_shift;
  logic                        found;
  logic [bmm_pkg::LVL_W-1:0]   found_lvl;

  assign fire        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || fire;
  assign accept      = in_i.valid && in_i.ready;
  assign is_scan     = (s1_mode_q == bmm_pkg::MODE_SUBJ) || (s1_mode_q == bmm_pkg::MODE_PAD);

  assign out_o.valid          = out_valid_q;
  assign out_o.match_start    = out_start_q;
  assign out_o.mismatch_count = out_count_q;

  always_comb begin
    if (len_q == '0) begin
      eff_len = bmm_pkg::SHIFT_W'(1);
    end else if (len_q > bmm_pkg::LEN_W'(bmm_pkg::WORD_BITS)) begin
      eff_len = bmm_pkg::SHIFT_W'(bmm_pkg::WORD_BITS);
    end else begin
      eff_len = bmm_pkg::SHIFT_W'(len_q);
    end
  end

  always_comb begin
    if (int'(maxerr_q) > bmm_pkg::MAX_ERRORS) begin
      eff_k = bmm_pkg::LVL_W'(bmm_pkg::MAX_ERRORS);
    end else begin
      eff_k = bmm_pkg::LVL_W'(maxerr_q);
    end
  end

  bmm_mask_gen u_mask_gen (
    .pattern_i    (store_q),
    .symbol_i     (s1_sym_q),
    .fixed_mode_i (fixed_q),
    .length_i     (eff_len),
    .mask_o       (sym_mask)
  );

  assign pm = (s1_mode_q == bmm_pkg::MODE_SUBJ) ? sym_mask : '1;

  // start masks: level e holds ones below length minus e
  always_comb begin
    init_masks[0] = '1 >> (bmm_pkg::SHIFT_W'(bmm_pkg::WORD_BITS) - eff_len);
    for (int e = 1; e < bmm_pkg::LEVELS; e++) begin
      init_masks[e] = init_masks[0] >> e;
    end
  end

  // one chain across levels; levels above the limit hold
  always_comb begin
    masks_d    = masks_q;
    prev_shift = masks_q[0] >> 1;
    cur_shift  = '0;
    masks_d[0] = prev_shift | pm;
    for (int e = 1; e < bmm_pkg::LEVELS; e++) begin
      cur_shift = masks_q[e] >> 1;
      if (bmm_pkg::LVL_W'(e) <= eff_k) begin
        masks_d[e] = (cur_shift | pm) & prev_shift & masks_d[e-1];
      end
      prev_shift = cur_shift;
    end
  end

  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int e = 0; e < bmm_pkg::LEVELS; e++) begin
      if (!found && (bmm_pkg::LVL_W'(e) <= eff_k) && !masks_d[e][0]) begin
        found     = 1'b1;
        found_lvl = bmm_pkg::LVL_W'(e);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= bmm_pkg::LEN_W'(1);
      maxerr_q <= '0;
      fixed_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmm_pkg::CFG_LENGTH: len_q    <= cfg_wdata_i[bmm_pkg::LEN_W-1:0];
        bmm_pkg::CFG_MAXERR: maxerr_q <= cfg_wdata_i[bmm_pkg::ERR_W-1:0];
        bmm_pkg::CFG_FIXED:  fixed_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= in_i.mode;
      s1_sym_q  <= in_i.symbol;
      s1_idx_q  <= in_i.pattern_index;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && (s1_mode_q == bmm_pkg::MODE_LOAD)) begin
      store_q[s1_idx_q] <= s1_sym_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // level 0 holds a single one, the rest are clear
      masks_q <= bmm_pkg::level_masks_t'(1);
      pos_q   <= '0;
    end else if (fire) begin
      unique case (s1_mode_q) inside
        bmm_pkg::MODE_LOAD: ;
        bmm_pkg::MODE_START: begin
          masks_q <= init_masks;
          pos_q   <= bmm_pkg::POS_W'(1) - bmm_pkg::POS_W'(eff_len);
        end
        bmm_pkg::MODE_SUBJ, bmm_pkg::MODE_PAD: begin
          masks_q <= masks_d;
          if (pos_q != bmm_pkg::POS_MAX) begin
            pos_q <= pos_q + bmm_pkg::POS_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && is_scan && found) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_scan && found) begin
      out_start_q <= pos_q;
      out_count_q <= bmm_pkg::ERR_W'(found_lvl);
    end
  end

endmodule
